// ===== hw/rtl/btlpm_pkg.sv =====
package btlpm_pkg;

    localparam int NODE_COUNT_DEFAULT = 4096;
    localparam int FIFO_DEPTH = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [5:0] MAX_PLEN = 6'd32;

    typedef struct packed {
        logic        opcode;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
        logic [7:0]  next_hop;
    } cmd_t;

endpackage

// ===== hw/rtl/btlpm_front.sv =====
module btlpm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [31:0]        ip_addr,
    input  logic [5:0]         prefix_len,
    input  logic [7:0]         next_hop,
    output logic               cmd_valid,
    output btlpm_pkg::cmd_t    cmd,
    input  logic               cmd_pop
);

    btlpm_pkg::cmd_t fifo_reg [btlpm_pkg::FIFO_DEPTH];
    logic rd_ptr_reg, rd_ptr_next;
    logic wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push;
    btlpm_pkg::cmd_t in_cmd;

    assign busy = (count_reg == 2'(btlpm_pkg::FIFO_DEPTH));
    assign push = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.opcode = opcode;
        in_cmd.ip_addr = ip_addr;
        in_cmd.next_hop = next_hop;
        // saturate long prefixes
        in_cmd.prefix_len = (prefix_len > btlpm_pkg::MAX_PLEN) ? btlpm_pkg::MAX_PLEN
                                                               : prefix_len;
        if (opcode == btlpm_pkg::OP_LOOKUP)
        begin
            in_cmd.prefix_len = btlpm_pkg::MAX_PLEN;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(btlpm_pkg::FIFO_DEPTH)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("queue underflow");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("count mismatch");
`endif

endmodule

// ===== hw/rtl/btlpm_back.sv =====
module btlpm_back
#(
    parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  btlpm_pkg::cmd_t    cmd,
    output logic               cmd_pop,
    output logic               done,
    output logic               hit,
    output logic [7:0]         port_out,
    output logic               status
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int NW = 1 + 8 + 2 * IW;
    localparam int FW = IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [NW-1:0] mem [NODE_COUNT];
    logic [NW-1:0] rd_data;
    logic root_init_reg;
    logic [NW-1:0] root_reg;

    logic [2:0] state_reg, state_next;
    btlpm_pkg::cmd_t cmd_reg;
    logic [IW-1:0] cur_reg, cur_next;
    logic [5:0] depth_reg, depth_next;
    logic [FW-1:0] free_reg, free_next;
    logic found_reg, found_next;
    logic [7:0] best_reg, best_next;
    logic err_reg, err_next;
    logic [NW-1:0] node_reg, node_next;

    logic we;
    logic [IW-1:0] waddr, raddr;
    logic [NW-1:0] wdata;
    logic [NW-1:0] node;
    logic n_has;
    logic [7:0] n_hop;
    logic [IW-1:0] n_left, n_right, n_child;
    logic dir;
    logic at_end;

    assign node = (cur_reg == '0) ? root_reg : rd_data;
    assign n_has = node_reg[NW-1];
    assign n_hop = node_reg[NW-2 -: 8];
    assign n_left = node_reg[2*IW-1 -: IW];
    assign n_right = node_reg[IW-1:0];
    assign dir = cmd_reg.ip_addr[5'(6'd31 - depth_reg)];
    assign n_child = dir ? n_right : n_left;
    assign at_end = (depth_reg == cmd_reg.prefix_len);
    assign raddr = cur_next;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        depth_next = depth_reg;
        free_next = free_reg;
        found_next = found_reg;
        best_next = best_reg;
        err_next = err_reg;
        node_next = node_reg;
        cmd_pop = 1'b0;
        we = 1'b0;
        waddr = cur_reg;
        wdata = node_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    cur_next = '0;
                    depth_next = 6'd0;
                    found_next = 1'b0;
                    best_next = 8'd0;
                    err_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                node_next = node;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (cmd_reg.opcode == btlpm_pkg::OP_LOOKUP)
                begin
                    if (n_has)
                    begin
                        found_next = 1'b1;
                        best_next = n_hop;
                    end
                    if (at_end || n_child == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = n_child;
                        depth_next = depth_reg + 6'd1;
                        state_next = S_READ;
                    end
                end
                else if (cmd_reg.prefix_len == 6'd0)
                begin
                    state_next = S_DONE;
                end
                else if (at_end)
                begin
                    if (!n_has)
                    begin
                        we = 1'b1;
                        wdata = {1'b1, cmd_reg.next_hop, n_left, n_right};
                    end
                    state_next = S_DONE;
                end
                else if (n_child != '0)
                begin
                    cur_next = n_child;
                    depth_next = depth_reg + 6'd1;
                    state_next = S_READ;
                end
                else if (free_reg >= FW'(NODE_COUNT))
                begin
                    err_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    we = 1'b1;
                    wdata = dir ? {node_reg[NW-1:IW], free_reg[IW-1:0]}
                                : {node_reg[NW-1 -: 9], free_reg[IW-1:0], n_right};
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                we = 1'b1;
                waddr = free_reg[IW-1:0];
                wdata = '0;
                cur_next = free_reg[IW-1:0];
                free_next = free_reg + FW'(1);
                depth_next = depth_reg + 6'd1;
                node_next = '0;
                state_next = S_EVAL;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done = (state_reg == S_DONE);
    assign hit = found_reg;
    assign port_out = found_reg ? best_reg : 8'd0;
    assign status = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg <= FW'(1);
            found_reg <= 1'b0;
            err_reg <= 1'b0;
            root_init_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            free_reg <= free_next;
            found_reg <= found_next;
            err_reg <= err_next;
            root_init_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (we && waddr == '0)
        begin
            root_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        cur_reg <= cur_next;
        depth_reg <= depth_next;
        best_reg <= best_next;
        node_reg <= node_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FW'(NODE_COUNT)) else $error("free index overrun");
    a_alloc_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC |=> state_reg == S_EVAL) else $error("alloc seq");
    a_err_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (cmd_reg.opcode == btlpm_pkg::OP_INSERT && !hit))
        else $error("bad status");
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> depth_reg <= 6'd32) else $error("depth range");
    a_root_init: assert property (@(posedge clk)
        root_init_reg |-> state_reg == S_IDLE) else $error("reset state");
`endif

endmodule

// ===== hw/rtl/binary_trie_longest_prefix_match_core.sv =====
// IPv4 longest-prefix-match engine on a binary trie.
// Command channel: drive opcode, ip_addr, prefix_len, next_hop with start;
// a command transfers at a rising edge where start is high and busy is low.
// opcode 0 inserts a route (first route per prefix wins), 1 looks up ip_addr.
// Result channel: done pulses for one cycle with hit, port_out and status;
// the receiver must take it then, results cannot be held off.
// A two-entry command queue lets new commands transfer while one runs.
// A lookup visits up to 33 trie levels, root included; an insert of length n
// visits n + 1 levels, existing or allocated alike. An existing level is read
// and then evaluated; an allocated one is cleared and then evaluated.
// Throughput is one command per walk; busy rises only when the queue is full.
// status 1 flags an insert that ran out of trie nodes.
// Reset clears the root, the queue and the free-node index; no clearing
// pass over the node memory is needed.
module binary_trie_longest_prefix_match_core
#(
    parameter int NODE_COUNT = btlpm_pkg::NODE_COUNT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] ip_addr,
    input  logic [5:0]  prefix_len,
    input  logic [7:0]  next_hop,
    output logic        done,
    output logic        hit,
    output logic [7:0]  port_out,
    output logic        status
);

    logic cmd_valid;
    logic cmd_pop;
    btlpm_pkg::cmd_t cmd;

    btlpm_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .ip_addr(ip_addr),
        .prefix_len(prefix_len),
        .next_hop(next_hop),
        .cmd_valid(cmd_valid),
        .cmd(cmd),
        .cmd_pop(cmd_pop)
    );

    btlpm_back #(.NODE_COUNT(NODE_COUNT)) u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd(cmd),
        .cmd_pop(cmd_pop),
        .done(done),
        .hit(hit),
        .port_out(port_out),
        .status(status)
    );

endmodule

// ===== dv/tb_binary_trie_longest_prefix_match_core.sv =====
`timescale 1ns / 1ps

module tb_binary_trie_longest_prefix_match_core;

    localparam logic       OP_INSERT = btlpm_pkg::OP_INSERT;
    localparam logic       OP_LOOKUP = btlpm_pkg::OP_LOOKUP;
    localparam logic [5:0] MAX_PLEN = btlpm_pkg::MAX_PLEN;

    localparam int NODES = 4096;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic       hit;
        logic [7:0] port_out;
        logic       status;
    } route_result_t;

    typedef struct {
        logic        opcode;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
        logic [7:0]  next_hop;
        logic        typed;
        logic        hit;
        logic [7:0]  port_out;
        logic        status;
    } route_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] ip_addr;
    logic [5:0]  prefix_len;
    logic [7:0]  next_hop;
    logic        done;
    logic        hit;
    logic [7:0]  port_out;
    logic        status;

    logic        trie_has_hop [NODES];
    logic [7:0]  trie_hop [NODES];
    int unsigned trie_child [NODES][2];
    int unsigned trie_next_free;

    route_result_t pending_results[$];
    route_cmd_t    directed_cmds[$];
    int            error_count;
    int            result_count;
    int            insert_count;
    int            lookup_count;
    int            full_count;
    int            cycle_count;
    logic [31:0]   route_pool [16];

    binary_trie_longest_prefix_match_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .ip_addr    (ip_addr),
        .prefix_len (prefix_len),
        .next_hop   (next_hop),
        .done       (done),
        .hit        (hit),
        .port_out   (port_out),
        .status     (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic route_result_t predict_route(input route_cmd_t c);
        route_result_t r;
        int unsigned   cur;
        int unsigned   nxt;
        int unsigned   dir;
        int unsigned   plen;
        r.hit = 1'b0;
        r.port_out = 8'd0;
        r.status = 1'b0;
        cur = 0;
        if (c.opcode == OP_INSERT)
        begin
            plen = (c.prefix_len > MAX_PLEN) ? 32 : 32'(c.prefix_len);
            for (int d = 0; d < plen; d++)
            begin
                dir = 32'(c.ip_addr[31 - d]);
                nxt = trie_child[cur][dir];
                if (nxt == 0)
                begin
                    if (trie_next_free >= NODES)
                    begin
                        r.status = 1'b1;
                        return r;
                    end
                    nxt = trie_next_free;
                    trie_next_free++;
                    trie_has_hop[nxt] = 1'b0;
                    trie_hop[nxt] = 8'd0;
                    trie_child[nxt][0] = 0;
                    trie_child[nxt][1] = 0;
                    trie_child[cur][dir] = nxt;
                end
                cur = nxt;
            end
            if (plen > 0 && !trie_has_hop[cur])
            begin
                trie_has_hop[cur] = 1'b1;
                trie_hop[cur] = c.next_hop;
            end
        end
        else
        begin
            for (int d = 0; d <= 32; d++)
            begin
                if (trie_has_hop[cur])
                begin
                    r.hit = 1'b1;
                    r.port_out = trie_hop[cur];
                end
                if (d == 32)
                    break;
                nxt = trie_child[cur][c.ip_addr[31 - d]];
                if (nxt == 0)
                    break;
                cur = nxt;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR %0t: result %0d %s got %0h expected %0h", $realtime, result_count,
                 what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        route_result_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("ERROR %0t: result with no command outstanding", $realtime);
                error_count++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (hit !== w.hit)
                    report_mismatch("hit", 8'(hit), 8'(w.hit));
                if (port_out !== w.port_out)
                    report_mismatch("port_out", port_out, w.port_out);
                if (status !== w.status)
                    report_mismatch("status", 8'(status), 8'(w.status));
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 1 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_cmd(input route_cmd_t c);
        route_result_t r;
        opcode     <= c.opcode;
        ip_addr    <= c.ip_addr;
        prefix_len <= c.prefix_len;
        next_hop   <= c.next_hop;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_route(c);
        if (c.typed && (r.hit !== c.hit || r.port_out !== c.port_out ||
                        r.status !== c.status))
        begin
            $display("ERROR: directed row for %h/%0d disagrees with prediction",
                     c.ip_addr, c.prefix_len);
            error_count++;
        end
        pending_results.push_back(r);
        if (c.opcode == OP_INSERT)
            insert_count++;
        else
            lookup_count++;
        if (r.status)
            full_count++;
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            idle_gap();
        end
    endtask

    function automatic route_cmd_t mk(input logic op, input logic [31:0] a,
                                      input logic [5:0] l, input logic [7:0] h,
                                      input logic t, input logic eh,
                                      input logic [7:0] ep, input logic es);
        route_cmd_t c;
        c.opcode = op;
        c.ip_addr = a;
        c.prefix_len = l;
        c.next_hop = h;
        c.typed = t;
        c.hit = eh;
        c.port_out = ep;
        c.status = es;
        return c;
    endfunction

    initial
    begin
        route_cmd_t c;
        int         sel;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_INSERT;
        ip_addr = '0;
        prefix_len = '0;
        next_hop = '0;
        error_count = 0;
        result_count = 0;
        insert_count = 0;
        lookup_count = 0;
        full_count = 0;
        cycle_count = 0;
        trie_next_free = 1;
        for (int i = 0; i < NODES; i++)
        begin
            trie_has_hop[i] = 1'b0;
            trie_hop[i] = 8'd0;
            trie_child[i][0] = 0;
            trie_child[i][1] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h0, 6'd63, 8'hFF,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 6'd0, 8'hAA,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0,
                                   1'b1, 1'b1, 8'hFF, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'h11,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 6'd5, 8'h3C,
                                   1'b1, 1'b1, 8'hFF, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'd0,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'h0000_0000, 6'd63, 8'h00,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'd0,
                                   1'b1, 1'b1, 8'h00, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'h8000_0000, 6'd1, 8'h80,
                                   1'b1, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'd0,
                                   1'b1, 1'b1, 8'h80, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'h0A00_0000, 6'd8, 8'h0A,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'h0A01_0000, 6'd16, 8'h55,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h0A02_0203, 6'd0, 8'd0,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_INSERT, 32'h5555_5555, 6'd33, 8'h5A,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        directed_cmds.push_back(mk(OP_LOOKUP, 32'h5555_5555, 6'd0, 8'd0,
                                   1'b0, 1'b0, 8'd0, 1'b0));
        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i]);

        for (int i = 0; i < 16; i++)
            route_pool[i] = $urandom();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            c.typed = 1'b0;
            c.hit = 1'b0;
            c.port_out = 8'd0;
            c.status = 1'b0;
            c.next_hop = 8'($urandom());
            c.prefix_len = 6'($urandom_range(0, 63));
            c.ip_addr = route_pool[$urandom_range(0, 15)];
            if (sel < 40)
            begin
                c.opcode = OP_INSERT;
                c.prefix_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                            : 6'($urandom_range(1, 32));
                if ($urandom_range(0, 3) == 0)
                    c.ip_addr = $urandom();
            end
            else
            begin
                c.opcode = OP_LOOKUP;
                if (sel < 85)
                    c.ip_addr = c.ip_addr ^ ($urandom() >> $urandom_range(0, 31));
                else
                    c.ip_addr = $urandom();
            end
            send_cmd(c);
        end
        // exhaust the node memory with deep unique routes
        while (full_count < 8)
        begin
            c = mk(OP_INSERT, $urandom(), 6'd32, 8'($urandom()), 1'b0, 1'b0, 8'd0, 1'b0);
            send_cmd(c);
            if ($urandom_range(0, 3) == 0)
            begin
                c = mk(OP_LOOKUP, c.ip_addr, 6'd0, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0);
                send_cmd(c);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Covered %0d inserts and %0d lookups, %0d results checked,",
                 insert_count, lookup_count, result_count);
        $display("%0d inserts hit the node limit, %0d nodes allocated.", full_count,
                 trie_next_free - 1);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/btlpm_pkg.sv
hw/rtl/btlpm_front.sv
hw/rtl/btlpm_back.sv
hw/rtl/binary_trie_longest_prefix_match_core.sv
dv/tb_binary_trie_longest_prefix_match_core.sv
